FILE: src/met_pkg.sv
// Shared types, widths and constants for the Mandelbrot escape-time block.
// Used by met_cfg, met_ctrl, met_dp and the top level mandelbrot_escape_time.
`timescale 1ns / 1ps
`default_nettype none

package met_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int SHADE_SPAN = 50;

  localparam int ITER_W  = 16;                 // max_iterations / iteration_count
  localparam int ZOOM_W  = 28;
  localparam int OFF_W   = 32;
  localparam int SHADE_W = 8;

  localparam int DIFF_W  = OFF_W + 1;          // pixel - offset, exact
  localparam int MAG_W   = OFF_W;              // |pixel - offset|
  localparam int REM_W   = ZOOM_W + 2;         // remainder stays below 4*zoom
  localparam int QUO_W   = FRAC_BITS + 2;      // 2 integer bits + fraction
  localparam int C_W     = FRAC_BITS + 4;      // c in [-4, 4]
  localparam int Z_W     = FRAC_BITS + 6;      // z after one step stays below 12
  localparam int MUL_W   = FRAC_BITS + 4;      // multiplier operand, |z| < 2 there
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam int SHADE_IW  = $clog2(SHADE_SPAN + 1);

  localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 1 + ITER_W + SHADE_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic signed [C_W-1:0] C_FOUR   = C_W'(4) << FRAC_BITS;
  localparam logic signed [Z_W-1:0] Z_TWO    = Z_W'(2) << FRAC_BITS;
  localparam logic signed [Z_W-1:0] Z_NTWO   = -Z_TWO;
  localparam logic signed [Z_W-1:0] Z_FOUR   = Z_W'(4) << FRAC_BITS;

  localparam logic [ITER_W-1:0]  MAX_ITER_RST = ITER_W'(200);
  localparam logic [ZOOM_W-1:0]  ZOOM_RST     = ZOOM_W'(200);
  localparam logic [OFF_W-1:0]   OFF_X_RST    = OFF_W'(450);
  localparam logic [OFF_W-1:0]   OFF_Y_RST    = OFF_W'(300);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITER = 8'd0,
    REG_ZOOM     = 8'd1,
    REG_OFF_X    = 8'd2,
    REG_OFF_Y    = 8'd3
  } met_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_CINIT = 5'b01000,
    ST_ITER  = 5'b10000
  } met_state_t;

  typedef struct packed {
    logic load;       // capture pixel, form pixel - offset
    logic div_prep;   // magnitude, clamp test, remainder seed
    logic div_step;   // one quotient bit per axis
    logic iter_init;  // sign and clamp c, clear z and count
    logic iter_step;  // z = z*z + c, count + 1
    logic out_load;   // capture result word
  } met_cmd_t;

  typedef struct packed {
    logic stop;
  } met_status_t;

  typedef logic [SHADE_W-1:0] shade_lut_t [SHADE_SPAN];

  function automatic shade_lut_t build_shade_lut();
    shade_lut_t t;
    for (int n = 0; n < SHADE_SPAN; n++) begin
      t[n] = SHADE_W'(((SHADE_SPAN - n) * 255) / SHADE_SPAN);
    end
    return t;
  endfunction

  localparam shade_lut_t SHADE_LUT = build_shade_lut();

endpackage

`default_nettype wire

FILE: src/mandelbrot_escape_time.sv
// Mandelbrot escape-time evaluator, one pixel per input word.
// Input word: in_tdata = {pixel_y, pixel_x}; output word: escaped, count, shade.
// Configuration: cfg_index selects max_iterations (0), zoom_scale (1),
// offset_x (2), offset_y (3); other indexes are ignored. cfg_ready is always
// high; write only while the block is idle.
// Per pixel: a load step, a prep step, restoring division to 30 quotient bits
// (both coordinates in parallel, one quotient bit per cycle), a step to form
// c, then the iteration unit (one complex squaring per cycle) until escape or
// the limit is reached. The iteration unit's loop sets the rate.
// One pixel is in work at a time; in_tready is high only when idle. The result
// sits in an output register, so a new pixel is taken while the last word
// waits. If out_tready stays low, the next pixel finishes and then holds in the
// iteration state until the output register frees up.
// Reset (rst_n low, synchronous) returns to idle, drops out_tvalid and loads
// the configuration defaults: limit 200, zoom 200, offsets 450 and 300.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [11:0] pixel_x, [23:12] pixel_y
  input  wire logic [met_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [0] escaped, [16:1] iteration_count, [24:17] shade, rest zero
  output logic [met_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [met_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [met_pkg::CFG_DATA_W-1:0] cfg_data
);
  import met_pkg::*;

  met_cmd_t            cmd;
  met_status_t         status;
  logic [ITER_W-1:0]   max_iter;
  logic [ZOOM_W-1:0]   zoom_eff;
  logic [OFF_W-1:0]    off_x, off_y;
  logic                escaped;
  logic [ITER_W-1:0]   iteration_count;
  logic [SHADE_W-1:0]  shade;

  assign cfg_ready = 1'b1;

  met_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .max_iter (max_iter),
    .zoom_eff (zoom_eff),
    .off_x    (off_x),
    .off_y    (off_y)
  );

  met_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  met_dp u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .pixel_x         (in_tdata[COORD_BITS-1:0]),
    .pixel_y         (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .max_iter        (max_iter),
    .zoom            (zoom_eff),
    .off_x           (off_x),
    .off_y           (off_y),
    .status          (status),
    .escaped         (escaped),
    .iteration_count (iteration_count),
    .shade           (shade)
  );

  assign out_tdata = OUT_TDATA_W'({shade, iteration_count, escaped});

endmodule

`default_nettype wire

FILE: src/met_cfg.sv
// Configuration register file: iteration limit, zoom and offsets.
// Depends on met_pkg.
`timescale 1ns / 1ps
`default_nettype none

module met_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [met_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [met_pkg::CFG_DATA_W-1:0] wr_data,
  output logic [met_pkg::ITER_W-1:0]          max_iter,
  output logic [met_pkg::ZOOM_W-1:0]          zoom_eff,
  output logic [met_pkg::OFF_W-1:0]           off_x,
  output logic [met_pkg::OFF_W-1:0]           off_y
);
  import met_pkg::*;

  logic [ITER_W-1:0] max_iter_r, max_iter_nxt;
  logic [ZOOM_W-1:0] zoom_r, zoom_nxt;
  logic [OFF_W-1:0]  off_x_r, off_x_nxt;
  logic [OFF_W-1:0]  off_y_r, off_y_nxt;

  always_comb begin
    max_iter_nxt = max_iter_r;
    zoom_nxt     = zoom_r;
    off_x_nxt    = off_x_r;
    off_y_nxt    = off_y_r;
    if (wr_en) begin
      case (met_reg_t'(wr_index))
        REG_MAX_ITER: max_iter_nxt = wr_data[ITER_W-1:0];
        REG_ZOOM:     zoom_nxt     = wr_data[ZOOM_W-1:0];
        REG_OFF_X:    off_x_nxt    = wr_data[OFF_W-1:0];
        REG_OFF_Y:    off_y_nxt    = wr_data[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RST;
      zoom_r     <= ZOOM_RST;
      off_x_r    <= OFF_X_RST;
      off_y_r    <= OFF_Y_RST;
    end else begin
      max_iter_r <= max_iter_nxt;
      zoom_r     <= zoom_nxt;
      off_x_r    <= off_x_nxt;
      off_y_r    <= off_y_nxt;
    end
  end

  assign max_iter = max_iter_r;
  // zero zoom acts as one
  assign zoom_eff = (zoom_r == '0) ? ZOOM_W'(1) : zoom_r;
  assign off_x    = off_x_r;
  assign off_y    = off_y_r;

endmodule

`default_nettype wire

FILE: src/met_ctrl.sv
// Controller: sequences load, coordinate division, iteration and result handoff.
// Depends on met_pkg; drives met_dp through met_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module met_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire met_pkg::met_status_t status,
  output met_pkg::met_cmd_t         cmd
);
  import met_pkg::*;

  met_state_t           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.div_prep = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(QUO_W - 1)) begin
          state_nxt = ST_CINIT;
        end
      end
      ST_CINIT: begin
        cmd.iter_init = 1'b1;
        state_nxt     = ST_ITER;
      end
      ST_ITER: begin
        if (status.stop) begin
          // hold here while the previous word is still waiting
          if (slot_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.iter_step = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: src/met_dp.sv
// Datapath: restoring coordinate dividers, z = z*z + c step unit, result word.
// Depends on met_pkg; controlled by met_ctrl through met_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module met_dp (
  input  wire logic                       clk,
  input  wire met_pkg::met_cmd_t          cmd,
  input  wire logic [met_pkg::COORD_BITS-1:0] pixel_x,
  input  wire logic [met_pkg::COORD_BITS-1:0] pixel_y,
  input  wire logic [met_pkg::ITER_W-1:0] max_iter,
  input  wire logic [met_pkg::ZOOM_W-1:0] zoom,
  input  wire logic [met_pkg::OFF_W-1:0]  off_x,
  input  wire logic [met_pkg::OFF_W-1:0]  off_y,
  output met_pkg::met_status_t            status,
  output logic                            escaped,
  output logic [met_pkg::ITER_W-1:0]      iteration_count,
  output logic [met_pkg::SHADE_W-1:0]     shade
);
  import met_pkg::*;

  // per-axis coordinate state, axis 0 = real, axis 1 = imaginary
  logic signed [DIFF_W-1:0] d_r     [2];
  logic                     neg_r   [2];
  logic                     clamp_r [2];
  logic [REM_W-1:0]         rem_r   [2];
  logic [QUO_W-1:0]         quo_r   [2];
  logic signed [C_W-1:0]    c_r     [2];

  logic signed [DIFF_W-1:0] d_nxt   [2];
  logic [MAG_W-1:0]         mag     [2];
  logic [REM_W-1:0]         rem_nxt [2];
  logic                     q_bit   [2];
  logic signed [C_W-1:0]    c_abs   [2];
  logic signed [C_W-1:0]    c_nxt   [2];
  logic [REM_W-1:0]         two_z;
  logic [MAG_W-1:0]         four_z;

  logic signed [Z_W-1:0]    re_r, im_r, re_nxt, im_nxt;
  logic [ITER_W-1:0]        count_r;

  logic signed [MUL_W-1:0]   m_re, m_im;
  logic signed [2*MUL_W-1:0] p_rr, p_ii, p_ri;
  logic signed [Z_W-1:0]     re2, im2, rim, sq_sum;
  logic                      outside;

  logic                      esc_r;
  logic [ITER_W-1:0]         cnt_out_r;
  logic [SHADE_W-1:0]        shade_r, shade_nxt;

  assign two_z  = REM_W'({zoom, 1'b0});
  assign four_z = MAG_W'({zoom, 2'b00});

  always_comb begin
    d_nxt[0] = DIFF_W'($signed({1'b0, pixel_x})) - DIFF_W'($signed(off_x));
    d_nxt[1] = DIFF_W'($signed({1'b0, pixel_y})) - DIFF_W'($signed(off_y));
    for (int i = 0; i < 2; i++) begin
      mag[i]     = MAG_W'(d_r[i][DIFF_W-1] ? -d_r[i] : d_r[i]);
      // remainder is kept below 2*zoom after the test, then doubled
      q_bit[i]   = (rem_r[i] >= two_z);
      rem_nxt[i] = REM_W'({(q_bit[i] ? (rem_r[i] - two_z) : rem_r[i]), 1'b0});
      c_abs[i]   = clamp_r[i] ? C_FOUR : C_W'(quo_r[i]);
      c_nxt[i]   = neg_r[i] ? -c_abs[i] : c_abs[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      if (cmd.load) begin
        d_r[i] <= d_nxt[i];
      end
      if (cmd.div_prep) begin
        neg_r[i]   <= d_r[i][DIFF_W-1];
        clamp_r[i] <= (mag[i] >= four_z);
        rem_r[i]   <= mag[i][REM_W-1:0];
        quo_r[i]   <= '0;
      end else if (cmd.div_step) begin
        rem_r[i] <= rem_nxt[i];
        quo_r[i] <= {quo_r[i][QUO_W-2:0], q_bit[i]};
      end
      if (cmd.iter_init) begin
        c_r[i] <= c_nxt[i];
      end
    end
  end

  // Products are only meaningful while |re|, |im| < 2; above that the
  // magnitude test alone decides escape.
  assign m_re = $signed(re_r[MUL_W-1:0]);
  assign m_im = $signed(im_r[MUL_W-1:0]);
  assign p_rr = m_re * m_re;
  assign p_ii = m_im * m_im;
  assign p_ri = m_re * m_im;

  // arithmetic slices give floor of the shifted product; 2*re*im uses F-1
  assign re2    = $signed(p_rr[FRAC_BITS +: Z_W]);
  assign im2    = $signed(p_ii[FRAC_BITS +: Z_W]);
  assign rim    = $signed(p_ri[FRAC_BITS-1 +: Z_W]);
  assign sq_sum = re2 + im2;

  assign outside = (re_r >= Z_TWO) || (re_r <= Z_NTWO) ||
                   (im_r >= Z_TWO) || (im_r <= Z_NTWO) ||
                   (sq_sum >= Z_FOUR);

  assign re_nxt = re2 - im2 + Z_W'(c_r[0]);
  assign im_nxt = rim + Z_W'(c_r[1]);

  always_ff @(posedge clk) begin
    if (cmd.iter_init) begin
      re_r    <= '0;
      im_r    <= '0;
      count_r <= '0;
    end else if (cmd.iter_step) begin
      re_r    <= re_nxt;
      im_r    <= im_nxt;
      count_r <= count_r + 1'b1;
    end
  end

  // escape wins over the limit, as both may hold on the same step
  assign status.stop = outside || (count_r >= max_iter);

  always_comb begin
    shade_nxt = '0;
    if (outside && (count_r < ITER_W'(SHADE_SPAN))) begin
      shade_nxt = SHADE_LUT[count_r[SHADE_IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      esc_r     <= outside;
      cnt_out_r <= count_r;
      shade_r   <= shade_nxt;
    end
  end

  assign escaped         = esc_r;
  assign iteration_count = cnt_out_r;
  assign shade           = shade_r;

endmodule

`default_nettype wire
